/* hw/rtl/edc_pkg.sv */
`default_nettype none

package edc_pkg;

   // Element and accumulator widths.
   localparam int DATA_WIDTH = 16;
   localparam int MAG_WIDTH  = DATA_WIDTH + 1;
   localparam int SQ_WIDTH   = 2 * MAG_WIDTH;
   localparam int ACC_WIDTH  = 2 * DATA_WIDTH + 10;
   localparam int ADD_WIDTH  = ACC_WIDTH + 1;

   // Square root: one result bit per iteration.
   localparam int ROOT_WIDTH = ACC_WIDTH / 2;
   localparam int REM_WIDTH  = ROOT_WIDTH + 3;
   localparam int CNT_WIDTH  = $clog2(ROOT_WIDTH);
   localparam int DIST_WIDTH = 21;

   localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

   // Input word: one element pair.
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] a_value;
      logic signed [DATA_WIDTH-1:0] b_value;
      logic                         last;
   } req_word_type;

   // Result word: distance and saturation flag.
   typedef struct packed {
      logic [DIST_WIDTH-1:0] distance;
      logic                  saturated;
   } rsp_word_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_ROOT,
      ST_WRITE
   } state_type;

   // Strobes from the sequencer to the datapath.
   typedef struct packed {
      logic load;
      logic square;
      logic acc_add;
      logic root_load;
      logic root_step;
   } ctrl_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic last;
      logic root_done;
   } status_type;

endpackage

`default_nettype wire

/* hw/rtl/edc_addsub.sv */
`default_nettype none

module edc_addsub
   import edc_pkg::*;
(
   input  wire logic [ADD_WIDTH-1:0] op_a,
   input  wire logic [ADD_WIDTH-1:0] op_b,
   input  wire logic                 carry_in,
   output logic      [ADD_WIDTH-1:0] sum,
   output logic                      carry_out
);

   // Shared adder: accumulation adds, root iterations subtract with carry in.
   assign {carry_out, sum} = {1'b0, op_a} + {1'b0, op_b} + {{ADD_WIDTH{1'b0}}, carry_in};

endmodule

`default_nettype wire

/* hw/rtl/edc_datapath.sv */
`default_nettype none

module edc_datapath
   import edc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_type              ctrl,
   input  wire req_word_type          req_word,
   output status_type                 status,
   output logic      [DIST_WIDTH-1:0] distance,
   output logic                       saturated
);

   logic [MAG_WIDTH-1:0]  mag_ff;
   logic                  last_ff;
   logic [SQ_WIDTH-1:0]   sq_ff;
   logic [ACC_WIDTH-1:0]  acc_ff;
   logic [ACC_WIDTH-1:0]  rad_ff;
   logic [REM_WIDTH-1:0]  rem_ff;
   logic [ROOT_WIDTH-1:0] root_ff;
   logic [CNT_WIDTH-1:0]  cnt_ff;
   logic                  sat_ff;

   logic [MAG_WIDTH-1:0]  diff_in;
   logic [MAG_WIDTH-1:0]  mag_in;
   logic [SQ_WIDTH-1:0]   sq_in;
   logic [REM_WIDTH-1:0]  rem_shift;
   logic [REM_WIDTH-1:0]  trial;
   logic [ADD_WIDTH-1:0]  op_a;
   logic [ADD_WIDTH-1:0]  op_b;
   logic                  carry_in;
   logic [ADD_WIDTH-1:0]  sum;
   logic                  carry_out;
   logic [ACC_WIDTH-1:0]  sat_sum;
   logic                  bit_set;

   // Magnitude of the difference of the sign-extended elements.
   assign diff_in = {req_word.a_value[DATA_WIDTH-1], req_word.a_value}
                  - {req_word.b_value[DATA_WIDTH-1], req_word.b_value};
   assign mag_in  = diff_in[MAG_WIDTH-1] ? (~diff_in + MAG_WIDTH'(1)) : diff_in;

   // Square of the magnitude.
   assign sq_in = mag_ff * mag_ff;

   // Next partial remainder and trial value of the root iteration.
   assign rem_shift = {rem_ff[REM_WIDTH-3:0], rad_ff[ACC_WIDTH-1 -: 2]};
   assign trial     = REM_WIDTH'({root_ff, 2'b01});

   // Operand selection for the shared adder.
   always_comb begin
      if (ctrl.root_step) begin
         op_a     = ADD_WIDTH'(rem_shift);
         op_b     = ~ADD_WIDTH'(trial);
         carry_in = 1'b1;
      end else begin
         op_a     = {1'b0, acc_ff};
         op_b     = ADD_WIDTH'(sq_ff);
         carry_in = 1'b0;
      end
   end

   edc_addsub u_addsub (
      .op_a      (op_a),
      .op_b      (op_b),
      .carry_in  (carry_in),
      .sum       (sum),
      .carry_out (carry_out)
   );

   // A carry out of the accumulator width clamps the sum to its maximum.
   assign sat_sum = sum[ACC_WIDTH] ? ACC_MAX : sum[ACC_WIDTH-1:0];

   // In a root iteration the carry out means the remainder covers the trial.
   assign bit_set = carry_out;

   // Element pair capture.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         mag_ff  <= mag_in;
         last_ff <= req_word.last;
      end
   end

   // Square register.
   always_ff @(posedge clock) begin
      if (ctrl.square) begin
         sq_ff <= sq_in;
      end
   end

   // Accumulator; it is handed to the root unit and cleared on the last pair.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctrl.root_load) begin
         acc_ff <= '0;
      end else if (ctrl.acc_add) begin
         acc_ff <= sat_sum;
      end
   end

   // Digit-by-digit square root, one root bit per cycle.
   always_ff @(posedge clock) begin
      if (ctrl.root_load) begin
         rad_ff  <= sat_sum;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
         sat_ff  <= (sat_sum == ACC_MAX);
      end else if (ctrl.root_step) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= bit_set ? sum[REM_WIDTH-1:0] : rem_shift;
         root_ff <= {root_ff[ROOT_WIDTH-2:0], bit_set};
         cnt_ff  <= cnt_ff + CNT_WIDTH'(1);
      end
   end

   assign status.last      = last_ff;
   assign status.root_done = (cnt_ff == CNT_WIDTH'(ROOT_WIDTH - 1));

   assign distance  = DIST_WIDTH'(root_ff);
   assign saturated = sat_ff;

endmodule

`default_nettype wire

/* hw/rtl/edc_control.sv */
`default_nettype none

module edc_control
   import edc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       out_free,
   input  wire status_type status,
   output logic            req_ready,
   output logic            out_load,
   output ctrl_type        ctrl
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            state_in = status.last ? ST_ROOT : ST_IDLE;
         end
         ST_ROOT: begin
            if (status.root_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready      = 1'b0;
      out_load       = 1'b0;
      ctrl           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         ST_SQUARE: begin
            ctrl.square = 1'b1;
         end
         ST_ACCUM: begin
            ctrl.acc_add   = ~status.last;
            ctrl.root_load = status.last;
         end
         ST_ROOT: begin
            ctrl.root_step = 1'b1;
         end
         ST_WRITE: begin
            out_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/euclidean_distance_core.sv */
`default_nettype none

// Euclidean distance of two streamed vectors.
// The req channel carries one word per element pair: a_value and b_value in
// signed Q8.8 and a last flag on the final pair. The squared difference of
// each pair is added to a 42-bit accumulator that clamps at its maximum.
// On the last pair one rsp word follows: the truncated square root of the
// sum as unsigned Q13.8, and a flag that is set when the sum stood at its
// maximum. The accumulator is then cleared for the next vector pair.
// An element pair goes through capture, square and accumulate on the shared
// adder; req_ready is high only in the idle state, so the next pair waits
// until the previous one is accumulated. A last pair then takes 21 root
// iterations on the same shared adder (one root bit each) and a write state
// that loads the output register; rsp_valid rises in the cycle after that.
// The output register holds the result while the receiver stalls; the next
// vector is accepted meanwhile, and only the next result waits for it.
// A synchronous reset clears the accumulator, the sequencer and rsp_valid.
module euclidean_distance_core
   import edc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   ctrl_type              ctrl;
   status_type            status;
   logic                  out_free;
   logic                  out_load;
   logic [DIST_WIDTH-1:0] distance;
   logic                  saturated;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   edc_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .status    (status),
      .req_ready (req_ready),
      .out_load  (out_load),
      .ctrl      (ctrl)
   );

   edc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_word  (req_word),
      .status    (status),
      .distance  (distance),
      .saturated (saturated)
   );

   // Output word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_word_ff.distance  <= distance;
         rsp_word_ff.saturated <= saturated;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import edc_pkg::*;

   localparam int RUN_LIMIT = 200000;

   // One element pair waiting to be sent, with its idle gap.
   typedef struct {
      req_word_type word;
      int unsigned  gap;
      bit           drain;
      bit           calm;
   } pending_pair_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   pending_pair_type       pair_queue[$];
   rsp_word_type           expected_distances[$];
   logic [ACC_WIDTH-1:0]   running_sum = '0;
   logic                   rsp_calm = 1'b0;
   bit                     calm_mode = 1'b0;
   int unsigned            stall_left = 0;
   int unsigned            error_count = 0;
   int unsigned            cycle_count = 0;

   euclidean_distance_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Truncated integer square root, one bit at a time from the top.
   function automatic logic [ROOT_WIDTH-1:0] floor_root(logic [ACC_WIDTH-1:0] value);
      logic [ROOT_WIDTH-1:0]   root;
      logic [2*ROOT_WIDTH-1:0] trial;
      root = '0;
      for (int i = ROOT_WIDTH - 1; i >= 0; i--) begin
         root[i] = 1'b1;
         trial = (2*ROOT_WIDTH)'(root) * (2*ROOT_WIDTH)'(root);
         if (trial > (2*ROOT_WIDTH)'(value)) begin
            root[i] = 1'b0;
         end
      end
      return root;
   endfunction

   // Adds the squared difference of one word to the running sum, clamping at
   // the maximum. A last word yields the expected distance and clears the sum.
   function automatic void accumulate_pair(req_word_type word);
      logic signed [DATA_WIDTH:0] diff;
      logic [MAG_WIDTH-1:0]       mag;
      logic [SQ_WIDTH-1:0]        square;
      logic [ADD_WIDTH-1:0]       total;
      rsp_word_type               result;
      diff   = word.a_value - word.b_value;
      mag    = diff[DATA_WIDTH] ? MAG_WIDTH'(-diff) : MAG_WIDTH'(diff);
      square = SQ_WIDTH'(mag) * SQ_WIDTH'(mag);
      total  = ADD_WIDTH'(running_sum) + ADD_WIDTH'(square);
      if (total > ADD_WIDTH'(ACC_MAX)) begin
         running_sum = ACC_MAX;
      end else begin
         running_sum = total[ACC_WIDTH-1:0];
      end
      if (word.last) begin
         result.distance  = DIST_WIDTH'(floor_root(running_sum));
         result.saturated = (running_sum == ACC_MAX);
         expected_distances.push_back(result);
         running_sum = '0;
      end
   endfunction

   // Element values lean toward the extremes, zero and small magnitudes.
   function automatic logic [DATA_WIDTH-1:0] pick_element();
      case ($urandom_range(0, 7))
         0: begin
            return {1'b0, {(DATA_WIDTH-1){1'b1}}};
         end
         1: begin
            return {1'b1, {(DATA_WIDTH-1){1'b0}}};
         end
         2: begin
            return '0;
         end
         3: begin
            return $urandom_range(0, 1) ? DATA_WIDTH'($urandom_range(0, 15))
                                        : -DATA_WIDTH'($urandom_range(1, 16));
         end
         default: begin
            return DATA_WIDTH'($urandom);
         end
      endcase
   endfunction

   task automatic queue_pair(input logic [DATA_WIDTH-1:0] a, input logic [DATA_WIDTH-1:0] b,
                             input logic last, input bit drain);
      pending_pair_type item;
      item.word.a_value = a;
      item.word.b_value = b;
      item.word.last    = last;
      item.gap          = calm_mode ? 0 : $urandom_range(0, 3);
      item.drain        = drain;
      item.calm         = calm_mode;
      pair_queue.push_back(item);
   endtask

   // Driver: presents the next word once its gap has run out.
   always @(posedge clock) begin : driver
      logic             next_valid;
      pending_pair_type head;
      if (reset) begin
         req_valid <= 1'b0;
         req_word  <= '0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            accumulate_pair(req_word);
            next_valid = 1'b0;
         end
         if (!next_valid && pair_queue.size() != 0) begin
            if (pair_queue[0].gap != 0) begin
               pair_queue[0].gap = pair_queue[0].gap - 1;
            end else if (!(pair_queue[0].drain && expected_distances.size() != 0)) begin
               head = pair_queue.pop_front();
               req_word <= head.word;
               rsp_calm <= head.calm;
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // Monitor: checks each result word against the oldest expectation and
   // stalls the result channel at random between words.
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      logic         next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         next_ready = rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_distances.size() == 0) begin
               $error("unexpected result word: distance %0d, saturated %0b",
                      rsp_word.distance, rsp_word.saturated);
               error_count++;
            end else begin
               want = expected_distances.pop_front();
               if (rsp_word.distance !== want.distance) begin
                  $error("distance: expected %0d, actual %0d",
                         want.distance, rsp_word.distance);
                  error_count++;
               end
               if (rsp_word.saturated !== want.saturated) begin
                  $error("saturated: expected %0b, actual %0b",
                         want.saturated, rsp_word.saturated);
                  error_count++;
               end
            end
            stall_left = rsp_calm ? 0 : $urandom_range(0, 3);
            next_ready = (stall_left == 0);
         end else if (!rsp_ready) begin
            if (stall_left <= 1) begin
               next_ready = 1'b1;
            end
            if (stall_left != 0) begin
               stall_left = stall_left - 1;
            end
         end
         rsp_ready <= next_ready;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Stimulus: directed vectors first, then random vectors.
   initial begin
      int unsigned random_pairs;
      int unsigned vec_len;
      int unsigned vec_count;
      random_pairs = 0;
      vec_count    = 0;

      // Single-pair vectors: zero, the extremes and other corner patterns.
      queue_pair(16'h0000, 16'h0000, 1'b1, 1'b0);
      queue_pair(16'h7FFF, 16'h8000, 1'b1, 1'b0);
      queue_pair(16'h8000, 16'h7FFF, 1'b1, 1'b0);
      queue_pair(16'h8000, 16'h8000, 1'b1, 1'b0);
      queue_pair(16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
      queue_pair(16'h0001, 16'h0000, 1'b1, 1'b0);
      queue_pair(16'h5555, 16'hAAAA, 1'b1, 1'b0);
      queue_pair(16'hAAAA, 16'h5555, 1'b1, 1'b0);

      // Short vectors with mixed signs.
      queue_pair(16'hFFFF, 16'h0000, 1'b0, 1'b0);
      queue_pair(16'h0000, 16'h0001, 1'b0, 1'b0);
      queue_pair(16'h0001, 16'h0001, 1'b1, 1'b0);
      queue_pair(16'h0300, 16'hFD00, 1'b0, 1'b0);
      queue_pair(16'hFC00, 16'h0000, 1'b0, 1'b0);
      queue_pair(16'h0100, 16'h0100, 1'b1, 1'b0);

      // A long vector that lands exactly on the accumulator maximum, stays
      // there on a zero pair, and then overflows and clamps on its last pair.
      // The sender first waits for every result to come back.
      for (int k = 0; k < 1024; k++) begin
         queue_pair(16'h7FFF, 16'h8000, 1'b0, k == 0);
      end
      queue_pair(16'd11585, 16'h0000, 1'b0, 1'b0);
      queue_pair(16'd66, 16'h0000, 1'b0, 1'b0);
      queue_pair(16'd11, 16'h0000, 1'b0, 1'b0);
      queue_pair(16'h0000, 16'h0001, 1'b0, 1'b0);
      queue_pair(16'h0000, 16'h0000, 1'b0, 1'b0);
      queue_pair(16'h8000, 16'h7FFF, 1'b1, 1'b0);

      // The sum must start from zero again after saturation.
      queue_pair(16'h0003, 16'h0000, 1'b0, 1'b0);
      queue_pair(16'h0000, 16'h0004, 1'b1, 1'b0);

      // Random vectors, mostly short, a few of 100 to 300 pairs.
      while (random_pairs < 250) begin
         if ($urandom_range(0, 7) == 0) begin
            calm_mode = ~calm_mode;
         end
         vec_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 12);
         for (int k = 0; k < vec_len; k++) begin
            queue_pair(pick_element(), pick_element(), k == vec_len - 1,
                       k == 0 && vec_count % 8 == 7);
         end
         random_pairs += vec_len;
         vec_count++;
      end

      // Let everything drain and every result come back, then wait on so that a stray result word is still caught.
      @(negedge reset);
      while (pair_queue.size() != 0 || req_valid || expected_distances.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/edc_pkg.sv
hw/rtl/edc_addsub.sv
hw/rtl/edc_datapath.sv
hw/rtl/edc_control.sv
hw/rtl/euclidean_distance_core.sv
tb/tb_top.sv
